FILE: hdl/npi_pkg.sv
`default_nettype none

package npi_pkg;

	// Nozzle count; the result word carries one drive bit for each of four nozzles.
	localparam int NOZZLES = 4;

	localparam int QDEPTH  = 2;    // command queue between the front and the back
	localparam int DIVD_W  = 18;   // width of duty * period
	localparam int DIVS_W  = 8;    // width of max_duty
	localparam int TIME_W  = 10;   // width of high and low times
	localparam logic [TIME_W-1:0] PHASE_MAX = '1;

	// request types
	localparam logic [2:0] REQ_TICK     = 3'd0;
	localparam logic [2:0] REQ_DUTY     = 3'd1;
	localparam logic [2:0] REQ_PUMP_ON  = 3'd2;
	localparam logic [2:0] REQ_PUMP_OFF = 3'd3;
	localparam logic [2:0] REQ_ALL_OFF  = 3'd4;

	// response codes
	localparam logic [3:0] RSP_NONE      = 4'd0;
	localparam logic [3:0] RSP_DUTY_SET  = 4'd1;
	localparam logic [3:0] RSP_PUMP_ON   = 4'd2;
	localparam logic [3:0] RSP_PUMP_OFF  = 4'd3;
	localparam logic [3:0] RSP_ALL_OFF   = 4'd4;
	localparam logic [3:0] RSP_PUMP_IDLE = 4'd5;
	localparam logic [3:0] RSP_TANK_LOW  = 4'd6;
	localparam logic [3:0] RSP_BAD_DUTY  = 4'd7;
	localparam logic [3:0] RSP_SHUTDOWN  = 4'd8;

	// configuration register indexes
	localparam logic [1:0] CFG_MAX_DUTY   = 2'd0;
	localparam logic [1:0] CFG_PERIOD     = 2'd1;
	localparam logic [1:0] CFG_TANK_IVAL  = 2'd2;
	localparam logic [1:0] CFG_LOW_LIMIT  = 2'd3;

	typedef struct packed {
		logic [2:0] req_type;
		logic       tank_low;
		logic [1:0] nozzle_index;
		logic [7:0] duty_value;
	} req_t;

	typedef struct packed {
		logic [3:0] resp_code;
		logic [3:0] nozzle_drive;
		logic       pump_drive;
	} rsp_t;

	typedef struct packed {
		logic [7:0]        max_duty;
		logic [TIME_W-1:0] period_ms;
		logic [15:0]       tank_interval_ms;
		logic [3:0]        low_tank_limit;
	} cfg_t;

	// decoded command classes
	typedef enum logic [2:0] {
		OP_TICK,
		OP_DUTY,
		OP_DUTY_ZERO,
		OP_PUMP_ON,
		OP_PUMP_OFF,
		OP_ALL_OFF,
		OP_BAD,
		OP_NOP
	} op_t;

	typedef struct packed {
		op_t        op;
		logic       tank_low;
		logic [1:0] idx;
		logic [7:0] duty;
	} cmd_t;

	typedef enum logic {
		ST_IDLE,
		ST_DIV
	} back_state_t;

endpackage

`default_nettype wire

FILE: hdl/npi_div.sv
`default_nettype none

module npi_div
	import npi_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [DIVD_W-1:0] dividend,
	input  wire logic [DIVS_W-1:0] divisor,
	output logic                   done,
	output logic [TIME_W-1:0]      quotient
);

	localparam int CNT_W = $clog2(DIVD_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DIVS_W-1:0] rem_q;
	logic [DIVD_W-1:0] quo_q;

	logic [DIVS_W:0]   rem_sh;
	logic              fits;

	// restoring division, one quotient bit per cycle
	assign rem_sh = {rem_q, quo_q[DIVD_W-1]};
	assign fits   = rem_sh >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? DIVS_W'(rem_sh - {1'b0, divisor}) : rem_sh[DIVS_W-1:0];
			quo_q <= {quo_q[DIVD_W-2:0], fits};
		end
	end

	// quotient never exceeds period_ms here
	assign done     = done_q;
	assign quotient = quo_q[TIME_W-1:0];

endmodule

`default_nettype wire

FILE: hdl/npi_front.sv
`default_nettype none

module npi_front
	import npi_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	output logic      full,
	input  wire req_t req,
	input  wire cfg_t cfg,
	output logic      cmd_valid,
	output cmd_t      cmd,
	input  wire logic cmd_pop
);

	localparam int PTR_W = $clog2(QDEPTH);
	localparam int CNT_W = $clog2(QDEPTH + 1);

	cmd_t             queue_q [QDEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	logic push_ok;
	cmd_t cls;

	assign full    = count_q == CNT_W'(QDEPTH);
	assign push_ok = push && !full;

	// classify the incoming word
	always_comb begin
		cls.tank_low = req.tank_low;
		cls.idx      = req.nozzle_index;
		cls.duty     = req.duty_value;
		unique case (req.req_type)
			REQ_TICK: cls.op = OP_TICK;
			REQ_DUTY: begin
				if (int'(req.nozzle_index) >= NOZZLES || req.duty_value > cfg.max_duty)
					cls.op = OP_BAD;
				else if (req.duty_value == '0)
					cls.op = OP_DUTY_ZERO;
				else
					cls.op = OP_DUTY;
			end
			REQ_PUMP_ON:  cls.op = OP_PUMP_ON;
			REQ_PUMP_OFF: cls.op = OP_PUMP_OFF;
			REQ_ALL_OFF:  cls.op = OP_ALL_OFF;
			default:      cls.op = OP_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_ok)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (cmd_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push_ok && !cmd_pop)
				count_q <= count_q + 1'b1;
			else if (!push_ok && cmd_pop)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push_ok)
			queue_q[wr_ptr_q] <= cls;
	end

	assign cmd_valid = count_q != '0;
	assign cmd       = queue_q[rd_ptr_q];

endmodule

`default_nettype wire

FILE: hdl/npi_back.sv
`default_nettype none

module npi_back
	import npi_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cfg_t cfg,
	input  wire logic cmd_valid,
	input  wire cmd_t cmd,
	output logic      cmd_pop,
	output logic      out_valid,
	output rsp_t      out_word,
	input  wire logic out_pop
);

	back_state_t state_q, state_nx;

	// nozzle state
	logic [7:0]        duty_q    [NOZZLES];
	logic [TIME_W-1:0] high_q    [NOZZLES];
	logic [TIME_W-1:0] low_q     [NOZZLES];
	logic              phase_q   [NOZZLES];
	logic              drive_q   [NOZZLES];
	logic [TIME_W-1:0] elapsed_q [NOZZLES];
	logic [7:0]        duty_nx    [NOZZLES];
	logic [TIME_W-1:0] high_nx    [NOZZLES];
	logic [TIME_W-1:0] low_nx     [NOZZLES];
	logic              phase_nx   [NOZZLES];
	logic              drive_nx   [NOZZLES];
	logic [TIME_W-1:0] elapsed_nx [NOZZLES];

	logic [15:0] tank_el_q, tank_el_nx;
	logic [3:0]  low_cnt_q, low_cnt_nx;
	logic        pump_q, pump_nx;

	// duty set held across the division
	logic [1:0]  div_idx_q;
	logic [7:0]  div_duty_q;

	logic        out_valid_q;
	rsp_t        out_q;

	logic        out_free;
	logic        exec;
	logic        div_start;
	logic        div_done;
	logic [TIME_W-1:0] div_quo;
	logic        wr_out;
	logic [3:0]  code;
	logic [3:0]  nz_bits;
	logic [DIVD_W-1:0] product;

	assign out_free = !out_valid_q || out_pop;
	assign exec     = (state_q == ST_IDLE) && cmd_valid && out_free;
	assign product  = DIVD_W'(cmd.duty) * DIVD_W'(cfg.period_ms);

	npi_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (product),
		.divisor  (cfg.max_duty),
		.done     (div_done),
		.quotient (div_quo)
	);

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: if (div_start) state_nx = ST_DIV;
			ST_DIV:  if (div_done)  state_nx = ST_IDLE;
			default: state_nx = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		cmd_pop   = 1'b0;
		div_start = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				cmd_pop   = exec;
				div_start = exec && (cmd.op == OP_DUTY) && pump_q;
			end
			ST_DIV: begin
				cmd_pop   = 1'b0;
				div_start = 1'b0;
			end
			default: begin
				cmd_pop   = 1'b0;
				div_start = 1'b0;
			end
		endcase
	end

	// datapath update
	always_comb begin
		duty_nx    = duty_q;
		high_nx    = high_q;
		low_nx     = low_q;
		phase_nx   = phase_q;
		drive_nx   = drive_q;
		elapsed_nx = elapsed_q;
		tank_el_nx = tank_el_q;
		low_cnt_nx = low_cnt_q;
		pump_nx    = pump_q;
		wr_out     = 1'b0;
		code       = RSP_NONE;

		if (exec) begin
			unique case (cmd.op)
				OP_TICK: begin
					wr_out = 1'b1;
					for (int n = 0; n < NOZZLES; n++) begin
						if (elapsed_q[n] < PHASE_MAX)
							elapsed_nx[n] = elapsed_q[n] + 1'b1;
						if (duty_q[n] != '0) begin
							if (phase_q[n] && elapsed_nx[n] >= high_q[n]) begin
								phase_nx[n]   = 1'b0;
								elapsed_nx[n] = '0;
								drive_nx[n]   = 1'b0;
							end else if (!phase_q[n] && elapsed_nx[n] >= low_q[n]) begin
								phase_nx[n]   = 1'b1;
								elapsed_nx[n] = '0;
								drive_nx[n]   = 1'b1;
							end
						end
					end
					if (tank_el_q >= cfg.tank_interval_ms) begin
						tank_el_nx = '0;
						if (!cmd.tank_low)
							low_cnt_nx = '0;
						else if (low_cnt_q < cfg.low_tank_limit && low_cnt_q != 4'hF)
							low_cnt_nx = low_cnt_q + 1'b1;
					end else begin
						tank_el_nx = tank_el_q + 1'b1;
					end
					if (low_cnt_nx >= cfg.low_tank_limit && pump_q) begin
						pump_nx = 1'b0;
						code    = RSP_SHUTDOWN;
						for (int n = 0; n < NOZZLES; n++) begin
							duty_nx[n]  = '0;
							phase_nx[n] = 1'b0;
							drive_nx[n] = 1'b0;
						end
					end
				end
				OP_DUTY: begin
					// pump running: result comes when the divider finishes
					if (!pump_q) begin
						wr_out = 1'b1;
						code   = RSP_PUMP_IDLE;
					end
				end
				OP_DUTY_ZERO: begin
					wr_out            = 1'b1;
					code              = RSP_DUTY_SET;
					duty_nx[cmd.idx]  = '0;
					drive_nx[cmd.idx] = 1'b0;
					high_nx[cmd.idx]  = '0;
					low_nx[cmd.idx]   = cfg.period_ms;
				end
				OP_PUMP_ON: begin
					wr_out = 1'b1;
					if (low_cnt_q < cfg.low_tank_limit) begin
						pump_nx = 1'b1;
						code    = RSP_PUMP_ON;
					end else begin
						code = RSP_TANK_LOW;
					end
				end
				OP_PUMP_OFF: begin
					wr_out  = 1'b1;
					pump_nx = 1'b0;
					code    = RSP_PUMP_OFF;
				end
				OP_ALL_OFF: begin
					wr_out = 1'b1;
					code   = RSP_ALL_OFF;
					for (int n = 0; n < NOZZLES; n++) begin
						duty_nx[n]  = '0;
						phase_nx[n] = 1'b0;
						drive_nx[n] = 1'b0;
					end
				end
				OP_BAD: begin
					wr_out = 1'b1;
					code   = RSP_BAD_DUTY;
				end
				OP_NOP: begin
					wr_out = 1'b1;
					code   = RSP_NONE;
				end
				default: begin
					wr_out = 1'b1;
					code   = RSP_NONE;
				end
			endcase
		end else if (state_q == ST_DIV && div_done) begin
			wr_out              = 1'b1;
			code                = RSP_DUTY_SET;
			duty_nx[div_idx_q]  = div_duty_q;
			high_nx[div_idx_q]  = div_quo;
			low_nx[div_idx_q]   = cfg.period_ms - div_quo;
		end

		for (int n = 0; n < NOZZLES; n++)
			nz_bits[n] = drive_nx[n];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			tank_el_q   <= '0;
			low_cnt_q   <= '0;
			pump_q      <= 1'b0;
			for (int n = 0; n < NOZZLES; n++) begin
				duty_q[n]    <= '0;
				high_q[n]    <= '0;
				low_q[n]     <= '0;
				phase_q[n]   <= 1'b0;
				drive_q[n]   <= 1'b0;
				elapsed_q[n] <= '0;
			end
		end else begin
			state_q   <= state_nx;
			tank_el_q <= tank_el_nx;
			low_cnt_q <= low_cnt_nx;
			pump_q    <= pump_nx;
			duty_q    <= duty_nx;
			high_q    <= high_nx;
			low_q     <= low_nx;
			phase_q   <= phase_nx;
			drive_q   <= drive_nx;
			elapsed_q <= elapsed_nx;
			if (wr_out)
				out_valid_q <= 1'b1;
			else if (out_pop)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (div_start) begin
			div_idx_q  <= cmd.idx;
			div_duty_q <= cmd.duty;
		end
		if (wr_out) begin
			out_q.resp_code    <= code;
			out_q.nozzle_drive <= nz_bits;
			out_q.pump_drive   <= pump_nx;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_q;

endmodule

`default_nettype wire

FILE: hdl/nozzle_pwm_pump_interlock.sv
// Four-nozzle millisecond PWM with pump control and low-tank interlock.
//
// Request side is a queue write port: a word goes in on a rising edge with
// push high and full low. Each word is a tick (with the tank sensor bit), a
// duty set, pump on, pump off or all off. Every word gives exactly one
// response word, read as a queue: the oldest response sits on rsp while
// empty is low and leaves on an edge with pop high.
// Config registers (max_duty, period_ms, tank_interval_ms, low_tank_limit)
// are written through cfg_we/cfg_index/cfg_data; the user writes them only
// while the block is idle, which the block itself does not enforce; they
// take effect on the next word. Timing: a two-entry command queue feeds
// the executing back end, which registers each response onto rsp; one
// word per cycle is sustained while pop keeps up and no division runs.
// An accepted nonzero duty set with the pump running goes through a
// serial divider (duty*period/max_duty, one bit per cycle over 18 bits),
// during which the back end takes nothing else. When the receiver stalls,
// the response register holds, the back end stops and the queue fills,
// then full rises. Reset clears all nozzle state, counters and pump,
// empties both queues and restores the config defaults.
`default_nettype none

module nozzle_pwm_pump_interlock
	import npi_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire req_t        req,
	output logic             empty,
	input  wire logic        pop,
	output rsp_t             rsp,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	cfg_t cfg_q;
	logic cmd_valid;
	cmd_t cmd;
	logic cmd_pop;
	logic out_valid;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_duty         <= 8'd50;
			cfg_q.period_ms        <= 10'd50;
			cfg_q.tank_interval_ms <= 16'd1000;
			cfg_q.low_tank_limit   <= 4'd3;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MAX_DUTY:  cfg_q.max_duty         <= cfg_data[7:0];
				CFG_PERIOD:    cfg_q.period_ms        <= cfg_data[TIME_W-1:0];
				CFG_TANK_IVAL: cfg_q.tank_interval_ms <= cfg_data;
				CFG_LOW_LIMIT: cfg_q.low_tank_limit   <= cfg_data[3:0];
				default:       cfg_q.low_tank_limit   <= cfg_q.low_tank_limit;
			endcase
		end
	end

	// front: classify and queue
	npi_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.req       (req),
		.cfg       (cfg_q),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	// back: execute, hold the response
	npi_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.out_valid (out_valid),
		.out_word  (rsp),
		.out_pop   (pop)
	);

	assign empty = !out_valid;

endmodule

`default_nettype wire
